### rtl/core/rsskey_pkg.sv
// Shared types, sizes and operation codes for the record sort and search block.
`default_nettype none
package rsskey_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDXC_W      = (CNT_W > 6) ? CNT_W : 6;
  localparam int CMPC_W      = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_READ   = 2'd1;
  localparam logic [1:0] FN_SORT   = 2'd2;
  localparam logic [1:0] FN_SEARCH = 2'd3;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        payload;
  } record_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         position;
    logic signed [31:0] key;
    logic [15:0]        payload;
  } result_t;

  // Clamp the programmed count to the table depth.
  function automatic logic [CNT_W-1:0] used_count(input logic [6:0] cnt);
    if (CMPC_W'(cnt) > CMPC_W'(TABLE_DEPTH)) begin
      return CNT_W'(TABLE_DEPTH);
    end
    return CNT_W'(cnt);
  endfunction

  function automatic logic index_in_range(input logic [5:0] idx);
    return IDXC_W'(idx) < IDXC_W'(TABLE_DEPTH);
  endfunction

endpackage
`default_nettype wire

### rtl/core/rsskey_if.sv
// Valid/ready channel interfaces for operation beats and result beats.
`default_nettype none
interface rsskey_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         index;
  logic signed [31:0] key;
  logic [15:0]        payload;

  modport source (output valid, output func, output index, output key, output payload,
                  input ready);
  modport sink (input valid, input func, input index, input key, input payload,
                output ready);
endinterface

interface rsskey_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [5:0]         position;
  logic signed [31:0] key_out;
  logic [15:0]        payload_out;

  modport source (output valid, output found, output position, output key_out,
                  output payload_out, input ready);
  modport sink (input valid, input found, input position, input key_out,
                input payload_out, output ready);
endinterface
`default_nettype wire

### rtl/core/record_sort_and_search_by_key_top.sv
// Top level of the record table with in-place exchange sort and linear key search.
`default_nettype none
// Record table of TABLE_DEPTH entries (signed 32-bit key, 16-bit payload) kept in one
// synchronous memory with one write and one registered read port. One operation beat is
// taken at a time; the result beat lands in an output register, so the next operation is
// accepted while a result still waits. Search reads the records up to the count clamped
// to the depth, one entry per cycle through the read port, and stops at the first match;
// sort streams one compare-and-swap per cycle in its inner loop, holding the smallest
// record so far (record i at first) in a register while each later record j is read
// and compared; on a swap the held record is written to slot j and record j is held
// instead. The held record is written home to slot i after its pass. Contents are
// undefined until written and need no clearing after reset. The count register is
// written through cfg_*, which is always ready; write it only while the block is idle.
module record_sort_and_search_by_key_top
  import rsskey_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  rsskey_in_if.sink        in_ch,
  rsskey_out_if.source     out_ch,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_OUT  = 3'd2;
  localparam logic [2:0] S_SI   = 3'd3;
  localparam logic [2:0] S_SH   = 3'd4;
  localparam logic [2:0] S_SJ   = 3'd5;
  localparam logic [2:0] S_QI   = 3'd6;

  record_t mem [TABLE_DEPTH];
  record_t rdata_r;

  logic [2:0]         state_r, state_nxt;
  logic [6:0]         count_r;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic               pv_r, pv_nxt;
  logic [ADDR_W-1:0]  pj_r, pj_nxt;
  record_t            held_r, held_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [5:0]         idx_r, idx_nxt;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;

  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  record_t            mem_wdata;
  logic               accept, issue, out_free;

  assign cfg_ready          = 1'b1;
  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign issue              = (j_r < n_r);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_res_r.found;
  assign out_ch.position    = out_res_r.position;
  assign out_ch.key_out     = out_res_r.key;
  assign out_ch.payload_out = out_res_r.payload;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pv_nxt        = 1'b0;
    pj_nxt        = pj_r;
    held_nxt      = held_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = held_r;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt = in_ch.key;
          idx_nxt = in_ch.index;
          n_nxt   = used_count(count_r);
          unique case (in_ch.func)
            FN_WRITE: begin
              // Store at once if the index is in range; the beat is echoed back, key and payload zeroed if not.
              mem_we           = index_in_range(in_ch.index);
              mem_waddr        = ADDR_W'(in_ch.index);
              mem_wdata        = '{key: in_ch.key, payload: in_ch.payload};
              res_nxt.found    = index_in_range(in_ch.index);
              res_nxt.position = in_ch.index;
              res_nxt.key      = index_in_range(in_ch.index) ? in_ch.key : '0;
              res_nxt.payload  = index_in_range(in_ch.index) ? in_ch.payload : '0;
              state_nxt        = S_OUT;
            end
            FN_READ: begin
              if (index_in_range(in_ch.index)) begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(in_ch.index);
                state_nxt = S_RD;
              end else begin
                res_nxt   = '{found: 1'b0, position: in_ch.index, key: '0, payload: '0};
                state_nxt = S_OUT;
              end
            end
            FN_SORT: begin
              i_nxt     = '0;
              state_nxt = S_SI;
            end
            FN_SEARCH: begin
              j_nxt     = '0;
              state_nxt = S_QI;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_RD: begin
        res_nxt   = '{found: 1'b1, position: idx_r, key: rdata_r.key,
                      payload: rdata_r.payload};
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      S_SI: begin
        // Start the pass for record i, or finish when fewer than two remain.
        if ((CNT_W + 1)'(i_r) + 1'b1 < (CNT_W + 1)'(n_r)) begin
          mem_re    = 1'b1;
          mem_raddr = i_r[ADDR_W-1:0];
          j_nxt     = CNT_W'(i_r + 1'b1);
          state_nxt = S_SH;
        end else begin
          res_nxt   = '{found: 1'b1, position: '0, key: '0, payload: '0};
          state_nxt = S_OUT;
        end
      end

      S_SH: begin
        held_nxt  = rdata_r;
        mem_re    = 1'b1;
        mem_raddr = j_r[ADDR_W-1:0];
        pv_nxt    = 1'b1;
        pj_nxt    = j_r[ADDR_W-1:0];
        j_nxt     = CNT_W'(j_r + 1'b1);
        state_nxt = S_SJ;
      end

      S_SJ: begin
        // Swap: the larger held record is written to slot j and the smaller record j is held.
        if (pv_r && (held_r.key > rdata_r.key)) begin
          mem_we    = 1'b1;
          mem_waddr = pj_r;
          mem_wdata = held_r;
          held_nxt  = rdata_r;
        end
        if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = j_r[ADDR_W-1:0];
          pv_nxt    = 1'b1;
          pj_nxt    = j_r[ADDR_W-1:0];
          j_nxt     = CNT_W'(j_r + 1'b1);
        end else if (!pv_r) begin
          // Pipe drained: put the held minimum home at slot i.
          mem_we    = 1'b1;
          mem_waddr = i_r[ADDR_W-1:0];
          mem_wdata = held_r;
          i_nxt     = CNT_W'(i_r + 1'b1);
          state_nxt = S_SI;
        end
      end

      S_QI: begin
        if (pv_r && (rdata_r.key == key_r)) begin
          res_nxt   = '{found: 1'b1, position: 6'(pj_r), key: rdata_r.key,
                        payload: rdata_r.payload};
          state_nxt = S_OUT;
        end else if (issue) begin
          mem_re    = 1'b1;
          mem_raddr = j_r[ADDR_W-1:0];
          pv_nxt    = 1'b1;
          pj_nxt    = j_r[ADDR_W-1:0];
          j_nxt     = CNT_W'(j_r + 1'b1);
        end else if (!pv_r) begin
          res_nxt   = '{found: 1'b0, position: '0, key: '0, payload: '0};
          state_nxt = S_OUT;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    pj_r      <= pj_nxt;
    held_r    <= held_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  // One operation at a time: an accepted beat closes the input until the result is queued.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input taken again right after an accepted beat");

  // The streaming pass never reads the slot it writes in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("memory read and write hit the same entry");

  // An in-flight read always lies inside the used part of the table.
  a_inflight_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (CNT_W'(pj_r) < n_r))
    else $error("in-flight read beyond the record count");

  // No read is left in flight once the block is back at idle.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pv_r)
    else $error("read still in flight while idle");

endmodule
`default_nettype wire
